// ===== rtl/gwsc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the greedy weighted set cover core: field widths, function and
// register codes, sequencer states. No dependencies.
package gwsc_pkg;

	localparam int FUNC_W  = 2;
	localparam int SIDX_W  = 6;
	localparam int TIDX_W  = 8;
	localparam int COST_W  = 16;
	localparam int MASK_W  = 64;
	localparam int TOTAL_W = 22;
	localparam int CNT_W   = 7;
	localparam int TAL_W   = 9;
	localparam int PROD_W  = TAL_W + COST_W;
	localparam int CIDX_W  = 2;
	localparam int CDAT_W  = 9;
	localparam int SCR_W   = 7;
	localparam int TCR_W   = 9;

	typedef enum logic [FUNC_W-1:0] {
		FN_COST  = 2'd0,
		FN_PAIR  = 2'd1,
		FN_CLEAR = 2'd2,
		FN_RUN   = 2'd3
	} func_t;

	localparam logic [CIDX_W-1:0] CFG_SENSOR_COUNT = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_TARGET_COUNT = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_PRUNE_ENABLE = 2'd2;

	localparam logic [SCR_W-1:0] SC_RESET = 7'd64;
	localparam logic [TCR_W-1:0] TC_RESET = 9'd256;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLR, ST_ADD_RD, ST_ADD_WR, ST_CHK, ST_TALLY,
		ST_SEL0, ST_SEL1, ST_SRD, ST_SM1, ST_SM2, ST_SCMP, ST_MARK, ST_REC,
		ST_PSWP, ST_PRD, ST_PCR, ST_PCMP, ST_PEND, ST_PSR, ST_PSW, ST_FIN
	} state_t;

endpackage

// ===== rtl/gwsc_intf.sv =====
`timescale 1ns / 1ps
// Channel interfaces: input item, result word, configuration write.
// Depends on gwsc_pkg.
interface gwsc_item_if;
	logic                         valid;
	logic                         ready;
	gwsc_pkg::func_t              func;
	logic [gwsc_pkg::SIDX_W-1:0]  sensor_index;
	logic [gwsc_pkg::TIDX_W-1:0]  target_index;
	logic [gwsc_pkg::COST_W-1:0]  cost;
	modport source (output valid, func, sensor_index, target_index, cost, input ready);
	modport sink (input valid, func, sensor_index, target_index, cost, output ready);
endinterface

interface gwsc_result_if;
	logic                          valid;
	logic                          ready;
	logic [gwsc_pkg::MASK_W-1:0]   selected_mask;
	logic [gwsc_pkg::TOTAL_W-1:0]  total_cost;
	logic [gwsc_pkg::CNT_W-1:0]    selected_count;
	logic                          status;
	modport source (output valid, selected_mask, total_cost, selected_count, status,
		input ready);
	modport sink (input valid, selected_mask, total_cost, selected_count, status,
		output ready);
endinterface

interface gwsc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [gwsc_pkg::CIDX_W-1:0]  index;
	logic [gwsc_pkg::CDAT_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gwsc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gwsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/greedy_weighted_set_cover_core.sv =====
`timescale 1ns / 1ps
// Top level of the greedy weighted set cover core: tables, sequencer, shared multiplier.
// Depends on gwsc_pkg, gwsc_intf, gwsc_ram.
//
//  channel  dir  word
//  item     in   func, sensor_index, target_index, cost
//  result   out  selected_mask, total_cost, selected_count, status
//  cfg      in   index, data (always ready)
//
// Cost load: written on accept. Coverage pair: a map read, then a map write.
// Clear: a sweep over all MAX_TARGETS map words. After reset the coverage map is
// swept to zero; item is not ready meanwhile. Run: accept, a check sweep (on failure
// straight to the final state), per greedy pass a tally sweep, select steps through
// the shared 9x16 multiplier, a mark sweep and a record step; a closing tally sweep;
// if pruning is enabled, per prune pass a sweep, read and compare steps per chosen
// sensor, an end step, then order entry shifts when a sensor drops; a final state.
// A result waiting on result.ready holds the core in its final state.
module greedy_weighted_set_cover_core #(
	parameter int MAX_SENSORS = 64,
	parameter int MAX_TARGETS = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	gwsc_item_if.sink     item,
	gwsc_result_if.source result,
	gwsc_cfg_if.sink      cfg
);
	import gwsc_pkg::*;

	localparam int SW  = $clog2(MAX_SENSORS);
	localparam int SCW = $clog2(MAX_SENSORS + 1);
	localparam int TW  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int TCW = $clog2(MAX_TARGETS + 1);
	localparam int NS  = MAX_SENSORS;

	state_t state_q, state_d;

	logic [SCR_W-1:0] sensor_count_q;
	logic [TCR_W-1:0] target_count_q;
	logic             prune_enable_q;

	logic [SCW-1:0] sc_q, sc_d;
	logic [TCW-1:0] tc_q;
	logic [NS-1:0]  use_q;
	logic           prune_q;

	logic [TCW-1:0] t_q;
	logic           vld_s1;
	logic [TW-1:0]  addr_s1;
	logic           issue, sweep_end;

	logic [SIDX_W-1:0] si_q;
	logic [TIDX_W-1:0] ti_q;

	logic             map_we;
	logic [TW-1:0]    map_waddr, map_raddr;
	logic [NS-1:0]    map_wdata, map_rd;
	logic             done_we;
	logic [0:0]       done_wdata, done_rd;
	logic             cost_we;
	logic [SW-1:0]    cost_raddr, cost_waddr;
	logic [COST_W-1:0] cost_wdata, cost_rd, cost_eff;
	logic [NS-1:0]    cost_vld_q;
	logic             cost_rv_q;
	logic             ord_we;
	logic [SW-1:0]    ord_waddr, ord_raddr, ord_wdata, ord_rd;

	logic [TAL_W-1:0] lane_q [NS];
	logic             any_unc_q, fail_q;
	logic [SW-1:0]    s_q, best_q, k_q, pick_k_q, ps_q, pick_s_q;
	logic [COST_W-1:0] cost_best_q, cost_s_q, pick_cost_q;
	logic [TAL_W-1:0] tally_best_q;
	logic [TAL_W-1:0] mul_a;
	logic [COST_W-1:0] mul_b;
	logic [PROD_W-1:0] mul_q, prod1_q;
	logic [NS-1:0]    chosen_q, nonred_q, cover_x;
	logic             ge2;
	logic [SCW-1:0]   total_q;
	logic [TOTAL_W-1:0] cost_sum_q;
	logic             found_q;
	logic             accept, in_sensor_ok, in_target_ok;

	logic                res_vld_q;
	logic [MASK_W-1:0]   res_mask_q;
	logic [TOTAL_W-1:0]  res_cost_q;
	logic [CNT_W-1:0]    res_cnt_q;
	logic                res_stat_q;

	gwsc_ram #(.WIDTH(NS), .DEPTH(MAX_TARGETS)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(map_raddr), .rdata(map_rd)
	);
	gwsc_ram #(.WIDTH(1), .DEPTH(MAX_TARGETS)) u_done (
		.clk(clk), .we(done_we), .waddr(addr_s1), .wdata(done_wdata),
		.raddr(t_q[TW-1:0]), .rdata(done_rd)
	);
	gwsc_ram #(.WIDTH(COST_W), .DEPTH(MAX_SENSORS)) u_cost (
		.clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
		.raddr(cost_raddr), .rdata(cost_rd)
	);
	gwsc_ram #(.WIDTH(SW), .DEPTH(MAX_SENSORS)) u_order (
		.clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
		.raddr(ord_raddr), .rdata(ord_rd)
	);

	assign accept       = item.valid && item.ready;
	assign in_sensor_ok = (int'(item.sensor_index) < MAX_SENSORS);
	assign in_target_ok = (int'(item.target_index) < MAX_TARGETS);
	assign cfg.ready    = 1'b1;
	assign cost_eff     = cost_rv_q ? cost_rd : COST_W'(1);
	assign cover_x      = map_rd & chosen_q;
	assign ge2          = |(cover_x & (cover_x - NS'(1)));

	always_comb begin
		if (sensor_count_q == '0) begin
			sc_d = SCW'(1);
		end else if (int'(sensor_count_q) > MAX_SENSORS) begin
			sc_d = SCW'(MAX_SENSORS);
		end else begin
			sc_d = SCW'(sensor_count_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (item.func)
						FN_COST:  state_d = ST_IDLE;
						FN_PAIR:  state_d = (in_sensor_ok && in_target_ok) ? ST_ADD_RD : ST_IDLE;
						FN_CLEAR: state_d = ST_CLR;
						FN_RUN:   state_d = ST_CHK;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLR:    if (t_q == TCW'(MAX_TARGETS - 1)) state_d = ST_IDLE;
			ST_ADD_RD: state_d = ST_ADD_WR;
			ST_ADD_WR: state_d = ST_IDLE;
			ST_CHK:    if (sweep_end) state_d = fail_q ? ST_FIN : ST_TALLY;
			ST_TALLY: begin
				if (sweep_end) begin
					if (any_unc_q) state_d = ST_SEL0;
					else state_d = prune_q ? ST_PSWP : ST_FIN;
				end
			end
			ST_SEL0:   state_d = ST_SEL1;
			ST_SEL1:   state_d = (sc_q == SCW'(1)) ? ST_MARK : ST_SRD;
			ST_SRD:    state_d = ST_SM1;
			ST_SM1:    state_d = ST_SM2;
			ST_SM2:    state_d = ST_SCMP;
			ST_SCMP:   state_d = ((SCW'(s_q) + SCW'(1)) == sc_q) ? ST_MARK : ST_SRD;
			ST_MARK:   if (sweep_end) state_d = ST_REC;
			ST_REC:    state_d = ST_TALLY;
			ST_PSWP:   if (sweep_end) state_d = ST_PRD;
			ST_PRD:    state_d = ST_PCR;
			ST_PCR:    state_d = ST_PCMP;
			ST_PCMP:   state_d = ((SCW'(k_q) + SCW'(1)) == total_q) ? ST_PEND : ST_PRD;
			ST_PEND:   state_d = found_q ? ST_PSR : ST_FIN;
			ST_PSR:    state_d = ((SCW'(k_q) + SCW'(1)) < total_q) ? ST_PSW : ST_PSWP;
			ST_PSW:    state_d = ST_PSR;
			ST_FIN:    if (!res_vld_q || result.ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		item.ready = 1'b0;
		issue      = 1'b0;
		map_we     = 1'b0;
		map_waddr  = t_q[TW-1:0];
		map_wdata  = '0;
		map_raddr  = t_q[TW-1:0];
		done_we    = 1'b0;
		done_wdata = 1'b0;
		cost_we    = 1'b0;
		cost_waddr = item.sensor_index[SW-1:0];
		cost_wdata = (item.cost == '0) ? COST_W'(1) : item.cost;
		cost_raddr = s_q;
		ord_we     = 1'b0;
		ord_waddr  = k_q;
		ord_wdata  = ord_rd;
		ord_raddr  = k_q;
		mul_a      = tally_best_q;
		mul_b      = cost_s_q;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				cost_we = accept && (item.func == FN_COST) && in_sensor_ok;
			end
			ST_CLR: map_we = 1'b1;
			ST_ADD_RD: map_raddr = TW'(ti_q);
			ST_ADD_WR: begin
				map_we    = 1'b1;
				map_waddr = TW'(ti_q);
				map_wdata = map_rd | (NS'(1) << si_q[SW-1:0]);
			end
			ST_CHK: begin
				issue   = (t_q < tc_q);
				done_we = vld_s1;
			end
			ST_TALLY: issue = (t_q < tc_q);
			ST_SEL0: cost_raddr = '0;
			ST_SM1: begin
				mul_a = lane_q[0];
				mul_b = cost_best_q;
			end
			ST_MARK: begin
				issue      = (t_q < tc_q);
				done_we    = vld_s1 && !done_rd[0] && map_rd[best_q];
				done_wdata = 1'b1;
			end
			ST_REC: begin
				ord_we    = 1'b1;
				ord_waddr = total_q[SW-1:0];
				ord_wdata = best_q;
			end
			ST_PSWP: issue = (t_q < tc_q);
			ST_PCR: cost_raddr = ord_rd;
			ST_PSR: ord_raddr = SW'(k_q + SW'(1));
			ST_PSW: ord_we = 1'b1;
			default: ;
		endcase
	end

	assign sweep_end = !issue && !vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLR;
			sensor_count_q <= SC_RESET;
			target_count_q <= TC_RESET;
			prune_enable_q <= 1'b1;
			t_q            <= '0;
			vld_s1         <= 1'b0;
			cost_vld_q     <= '0;
			res_vld_q      <= 1'b0;
			fail_q         <= 1'b0;
			found_q        <= 1'b0;
			any_unc_q      <= 1'b0;
			chosen_q       <= '0;
			total_q        <= '0;
			cost_sum_q     <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (state_d != state_q) begin
				t_q <= '0;
			end else if (issue || state_q == ST_CLR) begin
				t_q <= t_q + TCW'(1);
			end
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_SENSOR_COUNT: sensor_count_q <= cfg.data[SCR_W-1:0];
					CFG_TARGET_COUNT: target_count_q <= cfg.data[TCR_W-1:0];
					CFG_PRUNE_ENABLE: prune_enable_q <= cfg.data[0];
					default: ;
				endcase
			end
			if (cost_we) cost_vld_q[cost_waddr] <= 1'b1;
			if (state_q == ST_FIN && state_d == ST_IDLE) begin
				res_vld_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.func == FN_RUN) begin
						fail_q     <= 1'b0;
						chosen_q   <= '0;
						total_q    <= '0;
						cost_sum_q <= '0;
					end
				end
				ST_CHK: if (vld_s1 && (map_rd & use_q) == '0) fail_q <= 1'b1;
				ST_TALLY: if (vld_s1 && !done_rd[0]) any_unc_q <= 1'b1;
				ST_REC: begin
					total_q    <= total_q + SCW'(1);
					chosen_q   <= chosen_q | (NS'(1) << best_q);
					cost_sum_q <= cost_sum_q + TOTAL_W'(cost_best_q);
				end
				ST_PSWP: found_q <= 1'b0;
				ST_PCMP: begin
					if (!nonred_q[ps_q] && (!found_q || cost_eff > pick_cost_q)) begin
						found_q <= 1'b1;
					end
				end
				ST_PEND: begin
					if (found_q) begin
						chosen_q   <= chosen_q & ~(NS'(1) << pick_s_q);
						cost_sum_q <= cost_sum_q - TOTAL_W'(pick_cost_q);
					end
				end
				ST_PSR: if (state_d == ST_PSWP) total_q <= total_q - SCW'(1);
				default: ;
			endcase
			if (state_d == ST_TALLY && state_q != ST_TALLY) any_unc_q <= 1'b0;
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		addr_s1   <= t_q[TW-1:0];
		cost_rv_q <= cost_vld_q[cost_raddr];
		mul_q     <= {{COST_W{1'b0}}, mul_a} * {{TAL_W{1'b0}}, mul_b};
		if (state_d == ST_TALLY && state_q != ST_TALLY) begin
			for (int i = 0; i < NS; i++) lane_q[i] <= '0;
		end
		if (state_d == ST_PSWP && state_q != ST_PSWP) nonred_q <= '0;
		unique case (state_q)
			ST_IDLE: begin
				si_q <= item.sensor_index;
				ti_q <= item.target_index;
				if (accept && item.func == FN_RUN) begin
					sc_q    <= sc_d;
					prune_q <= prune_enable_q;
					if (target_count_q == '0) begin
						tc_q <= TCW'(1);
					end else if (int'(target_count_q) > MAX_TARGETS) begin
						tc_q <= TCW'(MAX_TARGETS);
					end else begin
						tc_q <= TCW'(target_count_q);
					end
					for (int i = 0; i < NS; i++) use_q[i] <= (i < int'(sc_d));
				end
			end
			ST_TALLY: begin
				if (vld_s1 && !done_rd[0]) begin
					for (int i = 0; i < NS; i++) begin
						if (map_rd[i] && use_q[i]) lane_q[i] <= lane_q[i] + TAL_W'(1);
					end
				end
			end
			ST_SEL1: begin
				cost_best_q  <= cost_eff;
				tally_best_q <= lane_q[0];
				best_q       <= '0;
				s_q          <= SW'(1);
				for (int i = 0; i < NS - 1; i++) lane_q[i] <= lane_q[i + 1];
				lane_q[NS - 1] <= '0;
			end
			ST_SM1: begin
				cost_s_q <= cost_eff;
			end
			ST_SM2: prod1_q <= mul_q;
			ST_SCMP: begin
				if (prod1_q > mul_q) begin
					best_q       <= s_q;
					cost_best_q  <= cost_s_q;
					tally_best_q <= lane_q[0];
				end
				s_q <= s_q + SW'(1);
				for (int i = 0; i < NS - 1; i++) lane_q[i] <= lane_q[i + 1];
				lane_q[NS - 1] <= '0;
			end
			ST_PSWP: begin
				if (vld_s1 && !ge2) nonred_q <= nonred_q | map_rd;
				k_q <= '0;
			end
			ST_PCR: ps_q <= ord_rd;
			ST_PCMP: begin
				if (!nonred_q[ps_q] && (!found_q || cost_eff > pick_cost_q)) begin
					pick_k_q    <= k_q;
					pick_s_q    <= ps_q;
					pick_cost_q <= cost_eff;
				end
				k_q <= k_q + SW'(1);
			end
			ST_PEND: k_q <= pick_k_q;
			ST_PSW: k_q <= k_q + SW'(1);
			ST_FIN: begin
				if (state_d == ST_IDLE) begin
					res_mask_q <= fail_q ? '0 : MASK_W'(chosen_q);
					res_cost_q <= fail_q ? '0 : cost_sum_q;
					res_cnt_q  <= fail_q ? '0 : CNT_W'(total_q);
					res_stat_q <= fail_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid          = res_vld_q;
	assign result.selected_mask  = res_mask_q;
	assign result.total_cost     = res_cost_q;
	assign result.selected_count = res_cnt_q;
	assign result.status         = res_stat_q;

	a_cmp_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCMP |-> $past(state_q) == ST_SM2)
		else $error("compare without second product");

	a_count_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !fail_q) |-> $countones(chosen_q) == int'(total_q))
		else $error("chosen count and mask disagree");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> $past(state_q) == ST_FIN)
		else $error("result word outside final state");
endmodule
